// ===== rtl/sbpd_pkg.sv =====
// Shared types and constants for the seven-bit packet deframer.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package sbpd_pkg;

  // Default receive buffer size in bytes. The supported range is 16 to 2048.
  localparam int unsigned RX_BUFFER_BYTES_DEF = 2048;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  localparam int unsigned SYM_W = 7;
  localparam int unsigned LEN_W = 14;
  localparam int unsigned CRC_W = 32;
  localparam int unsigned IDX_W = 11;
  // Wide enough for any length, buffer size or index plus seven.
  localparam int unsigned CMP_W = 15;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_SYM   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SYM_W-1:0]  sym;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_LEN1  = 4'd1,
    PH_LEN2  = 4'd2,
    PH_CRC1  = 4'd3,
    PH_CRC2  = 4'd4,
    PH_CRC3  = 4'd5,
    PH_CRC4  = 4'd6,
    PH_CRC5  = 4'd7,
    PH_DATA0 = 4'd8,
    PH_DATA1 = 4'd9,
    PH_DATA2 = 4'd10,
    PH_DATA3 = 4'd11,
    PH_DATA4 = 4'd12,
    PH_DATA5 = 4'd13,
    PH_DATA6 = 4'd14,
    PH_DATA7 = 4'd15
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/sbpd_front.sv =====
// Front end: accepts received bytes and classifies them into queue commands.
// Depends on sbpd_pkg.
`default_nettype none

module sbpd_front (
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  output logic               in_ready,
  input  wire logic          push_ready,
  output logic               push_valid,
  output sbpd_pkg::cmd_t     push_cmd
);
  import sbpd_pkg::*;

  logic keep;

  always_comb begin
    push_cmd.sym  = in_byte[SYM_W-1:0];
    push_cmd.kind = CMD_SYM;
    keep          = 1'b1;
    priority if (in_byte == CH_OPEN) begin
      push_cmd.kind = CMD_OPEN;
    end else if (in_byte == CH_CLOSE) begin
      push_cmd.kind = CMD_CLOSE;
    end else if (in_byte[7]) begin
      push_cmd.kind = CMD_SYM;
    end else begin
      // Any other plain byte carries nothing and is dropped here.
      keep = 1'b0;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && push_ready && keep;

endmodule

`default_nettype wire

// ===== rtl/sbpd_queue.sv =====
// Short command queue between the front end and the frame engine.
// Depends on sbpd_pkg.
`default_nettype none

module sbpd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  input  wire sbpd_pkg::cmd_t push_cmd,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               head_valid,
  output sbpd_pkg::cmd_t     head_cmd
);
  import sbpd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_pop;

  assign push_ready = (count_r != FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_valid && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push_valid && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbpd_back.sv =====
// Frame engine: runs the phase machine on queued commands and holds the
// result beat in an output register. Depends on sbpd_pkg.
`default_nettype none

module sbpd_back #(
  parameter int unsigned RX_BUFFER_BYTES = sbpd_pkg::RX_BUFFER_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire sbpd_pkg::cmd_t            q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_is_end,
  output logic [7:0]                     out_data_byte,
  output logic [sbpd_pkg::IDX_W-1:0]     out_byte_index,
  output logic [sbpd_pkg::LEN_W-1:0]     out_frame_length,
  output logic [sbpd_pkg::CRC_W-1:0]     out_frame_crc,
  output logic                           out_was_in_frame
);
  import sbpd_pkg::*;

  localparam int unsigned GB_W = $clog2(RX_BUFFER_BYTES);
  localparam logic [CMP_W-1:0] RX_LIM = CMP_W'(RX_BUFFER_BYTES);
  localparam logic [CMP_W-1:0] GROUP  = CMP_W'(7);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [GB_W-1:0]  group_base_r, group_base_nxt;
  logic [SYM_W-1:0] carry_r, carry_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             is_end_r, is_end_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [IDX_W-1:0] index_r, index_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic [CRC_W-1:0] fcrc_r, fcrc_nxt;
  logic             in_frame_r, in_frame_nxt;

  logic             emit;
  logic [SYM_W-1:0] sym;
  logic [CMP_W-1:0] gb_ext, len_ext, idx, gb_step;
  logic             overrun;
  logic [2:0]       k;
  logic [7:0]       d_byte;
  logic [LEN_W-1:0] len_full;

  always_comb begin
    sym      = q_cmd.sym;
    gb_ext   = CMP_W'(group_base_r);
    len_ext  = CMP_W'(length_r);
    gb_step  = gb_ext + GROUP;
    overrun  = (len_ext >= RX_LIM) || (gb_step >= RX_LIM);
    // In data phases the low three phase bits count the symbol in the group.
    k        = phase_r[2:0];
    // Byte k-1 of the group is the low 8-k carry bits joined to the top k bits
    // of the new symbol.
    d_byte   = 8'({carry_r, sym} >> (3'd7 - k));
    idx      = gb_ext + CMP_W'(k) - CMP_W'(1);
    len_full = length_r | LEN_W'(sym);
  end

  always_comb begin
    phase_nxt      = phase_r;
    length_nxt     = length_r;
    crc_nxt        = crc_r;
    group_base_nxt = group_base_r;
    carry_nxt      = carry_r;
    emit           = 1'b0;
    is_end_nxt     = 1'b0;
    data_nxt       = '0;
    index_nxt      = '0;
    flen_nxt       = '0;
    fcrc_nxt       = '0;
    in_frame_nxt   = 1'b0;

    q_pop = q_valid && (!out_valid_r || out_ready);

    if (q_pop) begin
      unique case (q_cmd.kind)
        CMD_OPEN: begin
          phase_nxt  = PH_LEN1;
          length_nxt = '0;
        end
        CMD_CLOSE: begin
          emit         = 1'b1;
          is_end_nxt   = 1'b1;
          flen_nxt     = length_r;
          fcrc_nxt     = crc_r;
          in_frame_nxt = (phase_r != PH_IDLE);
          phase_nxt    = PH_IDLE;
        end
        CMD_SYM: begin
          if (overrun) begin
            phase_nxt      = PH_IDLE;
            group_base_nxt = '0;
            length_nxt     = '0;
          end else begin
            unique case (phase_r)
              PH_IDLE: begin
              end
              PH_LEN1: begin
                length_nxt = {sym, 7'b0};
                phase_nxt  = PH_LEN2;
              end
              PH_LEN2: begin
                length_nxt = len_full;
                // A length too large for the buffer leaves the block idle;
                // later symbols are still checked by the overrun guard.
                if (CMP_W'(len_full) + GROUP < RX_LIM) begin
                  phase_nxt      = PH_CRC1;
                  group_base_nxt = '0;
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end
              PH_CRC1: begin
                crc_nxt   = CRC_W'(sym) << 25;
                phase_nxt = PH_CRC2;
              end
              PH_CRC2: begin
                crc_nxt   = crc_r | (CRC_W'(sym) << 18);
                phase_nxt = PH_CRC3;
              end
              PH_CRC3: begin
                crc_nxt   = crc_r | (CRC_W'(sym) << 11);
                phase_nxt = PH_CRC4;
              end
              PH_CRC4: begin
                crc_nxt   = crc_r | (CRC_W'(sym) << 4);
                phase_nxt = PH_CRC5;
              end
              PH_CRC5: begin
                crc_nxt   = crc_r | CRC_W'(sym);
                phase_nxt = PH_DATA0;
              end
              PH_DATA0: begin
                carry_nxt = sym;
                phase_nxt = PH_DATA1;
              end
              PH_DATA1, PH_DATA2, PH_DATA3, PH_DATA4,
              PH_DATA5, PH_DATA6, PH_DATA7: begin
                // Padding past the frame length is unpacked but not sent.
                if (idx < len_ext) begin
                  emit      = 1'b1;
                  data_nxt  = d_byte;
                  index_nxt = idx[IDX_W-1:0];
                end
                carry_nxt = sym;
                if (phase_r == PH_DATA7) begin
                  group_base_nxt = gb_step[GB_W-1:0];
                  phase_nxt      = PH_DATA0;
                end else begin
                  phase_nxt = phase_t'(phase_r + 4'd1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      length_r     <= '0;
      crc_r        <= '0;
      group_base_r <= '0;
      carry_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      length_r     <= length_nxt;
      crc_r        <= crc_nxt;
      group_base_r <= group_base_nxt;
      carry_r      <= carry_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_end_r   <= is_end_nxt;
      data_r     <= data_nxt;
      index_r    <= index_nxt;
      flen_r     <= flen_nxt;
      fcrc_r     <= fcrc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_end       = is_end_r;
  assign out_data_byte    = data_r;
  assign out_byte_index   = index_r;
  assign out_frame_length = flen_r;
  assign out_frame_crc    = fcrc_r;
  assign out_was_in_frame = in_frame_r;

endmodule

`default_nettype wire

// ===== rtl/seven_bit_packet_deframer_core.sv =====
// Seven-bit packet deframer, top level.
// Input channel: one received byte per beat on in_byte with in_valid/in_ready.
// '{' opens a frame, '}' closes it, and bytes with the top bit set carry seven
// payload bits each (two length symbols, five CRC symbols, then groups of
// eight symbols that unpack to seven data bytes). Other bytes are dropped.
// Output channel: one result per beat with out_valid/out_ready; out_is_end
// marks an end report carrying length, CRC and whether a frame was open,
// otherwise the beat is a data byte with its index inside the payload.
// Throughput is one byte per cycle while out_ready stays high: the front
// classifies a byte in the cycle it is accepted, a two-entry queue registers
// it, and the frame engine executes one command per cycle into an output
// register. With nothing queued ahead, a byte passes the queue entry and
// then the output register before its result is valid. When the receiver
// stalls, the output register holds its beat, the engine waits, the queue
// fills and in_ready drops once it holds two marker or symbol bytes.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and returns the engine to idle with length, CRC and position cleared.
// Depends on sbpd_pkg, sbpd_front, sbpd_queue and sbpd_back.
`default_nettype none

module seven_bit_packet_deframer_core #(
  parameter int unsigned RX_BUFFER_BYTES = sbpd_pkg::RX_BUFFER_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_is_end,
  output logic [7:0]                     out_data_byte,
  output logic [sbpd_pkg::IDX_W-1:0]     out_byte_index,
  output logic [sbpd_pkg::LEN_W-1:0]     out_frame_length,
  output logic [sbpd_pkg::CRC_W-1:0]     out_frame_crc,
  output logic                           out_was_in_frame
);
  import sbpd_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic head_valid, pop;
  cmd_t head_cmd;

  sbpd_front u_front (
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_ready   (in_ready),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  sbpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sbpd_back #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (head_valid),
    .q_cmd            (head_cmd),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_end       (out_is_end),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_frame_crc    (out_frame_crc),
    .out_was_in_frame (out_was_in_frame)
  );

endmodule

`default_nettype wire
